// File: hdl/syndrome_coverage_counter_assert.svh
// Assertion macros for the syndrome coverage counter.
// Used by the top level; no other dependencies.
`ifndef SYNDROME_COVERAGE_COUNTER_ASSERT_SVH
`define SYNDROME_COVERAGE_COUNTER_ASSERT_SVH
`ifndef SYNTHESIS
`define SCC_ASSERT_IMP(label, clk, rst_n, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
        else $error("label failed");
`define SCC_ASSERT_NEXT(label, clk, rst_n, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
        else $error("label failed");
`else
`define SCC_ASSERT_IMP(label, clk, rst_n, a, c)
`define SCC_ASSERT_NEXT(label, clk, rst_n, a, c)
`endif
`endif

// File: hdl/scc_pkg.sv
// Package for the syndrome coverage counter: default sizes and request codes.
// No dependencies.
`default_nettype none
package scc_pkg;
    localparam int SYN_BITS_DEF = 10;
    localparam int SLOTS_DEF    = 50;
    localparam logic [1:0] REQ_CLEAR  = 2'd0;
    localparam logic [1:0] REQ_APPEND = 2'd1;
    localparam logic [1:0] REQ_SWAP   = 2'd2;
    localparam logic STAT_DONE = 1'b0;
    localparam logic STAT_REJ  = 1'b1;
endpackage
`default_nettype wire

// File: hdl/scc_count_mem.sv
// Syndrome count memory, 1R1W, registered read; cleared by the top level's write sweep.
// Depends on scc_pkg.
`default_nettype none
module scc_count_mem import scc_pkg::*; #(
    parameter int SYN_BITS = SYN_BITS_DEF
) (
    input  wire                 i_clk,
    input  wire [SYN_BITS-1:0]  i_raddr,
    output logic [6:0]          o_rdata,
    input  wire                 i_we,
    input  wire [SYN_BITS-1:0]  i_waddr,
    input  wire [6:0]           i_wdata
);
    // bit 6: present mark, bits 5:0: count
    logic [6:0] r_mem [2**SYN_BITS];
    always_ff @(posedge i_clk) begin
        if (i_we) r_mem[i_waddr] <= i_wdata;
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

// File: hdl/syndrome_coverage_counter.sv
// Top level of the syndrome coverage counter: sequencer, column store, totals.
// Depends on scc_pkg, scc_count_mem and syndrome_coverage_counter_assert.svh.
//
//  channel | valid   | ready   | payload
//  request | i_valid | o_ready | i_req_type i_slot i_new_column
//  result  | o_valid | i_ready | o_status .. o_drop_slot
//
// Count memory has registered read: each count update is read, wait, write.
// After acceptance: check; append updates the column and its pairs; swap removes the old
// column, then adds the new; then scoring when full, else straight to the result.
// Clear and reset sweep the whole count memory; no request is taken meanwhile.
// Ready is low from acceptance until the result has been taken.
`default_nettype none
module syndrome_coverage_counter import scc_pkg::*; #(
    parameter int SYNDROME_BITS = SYN_BITS_DEF,
    parameter int COLUMN_SLOTS  = SLOTS_DEF
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_valid,
    output logic        o_ready,
    input  wire [1:0]   i_req_type,
    input  wire [5:0]   i_slot,
    input  wire [9:0]   i_new_column,
    output logic        o_valid,
    input  wire         i_ready,
    output logic        o_status,
    output logic [10:0] o_uncovered_count,
    output logic [10:0] o_single_count,
    output logic        o_score_valid,
    output logic [10:0] o_deletion_score,
    output logic [5:0]  o_drop_slot
);
`include "syndrome_coverage_counter_assert.svh"
    localparam int SB = SYNDROME_BITS;
    localparam int IW = (COLUMN_SLOTS > 1) ? $clog2(COLUMN_SLOTS) : 1;
    localparam int CW = $clog2(COLUMN_SLOTS + 1);
    localparam int TW = SB + 1;
    localparam logic [TW-1:0] HOLE_RST = TW'((2**SB) - 1);

    localparam logic [3:0] S_CLR = 4'd0, S_IDLE = 4'd1, S_CHK = 4'd2, S_CHKW = 4'd3,
        S_RD = 4'd4, S_RW = 4'd5, S_WR = 4'd6, S_MARK = 4'd7, S_SRD = 4'd8,
        S_SRW = 4'd9, S_SACC = 4'd10, S_OUT = 4'd11, S_MRD = 4'd12;

    logic [3:0]    r_st, n_st;
    logic [SB-1:0] r_col [COLUMN_SLOTS];
    logic [CW-1:0] r_loaded;
    logic [TW-1:0] r_hole, r_single;
    logic [1:0]    r_req;
    logic [IW-1:0] r_slot;
    logic          r_slot_ok;
    logic [SB-1:0] r_val, r_old;
    logic          r_phase;   // swap: 0 removing old, 1 adding new
    logic [CW-1:0] r_i;       // pair index, COLUMN_SLOTS means the column itself
    logic [IW-1:0] r_s;
    logic [CW-1:0] r_j;
    logic [CW-1:0] r_dmg, r_best;
    logic [IW-1:0] r_bslot;
    logic [SB-1:0] r_clr;
    logic          r_status;

    logic [SB-1:0] m_raddr, m_waddr;
    logic [6:0]    m_rdata, m_wdata;
    logic          m_we;

    // column store read ports, registered: A for the scored/old column, B for the pair
    logic [IW-1:0] ca_addr, cb_addr;
    logic [SB-1:0] r_ca, r_cb;

    scc_count_mem #(.SYN_BITS(SB)) u_mem (
        .i_clk(i_clk), .i_raddr(m_raddr), .o_rdata(m_rdata),
        .i_we(m_we), .i_waddr(m_waddr), .i_wdata(m_wdata)
    );

    logic [SB-1:0] cur_c, bump_addr;
    logic [IW-1:0] i_idx, j_idx;
    logic          skip_i, skip_j, last_i;
    logic [5:0]    cnt_b, cnt_a;
    logic          up;
    logic          full;
    logic          rej;
    assign i_idx  = r_i[IW-1:0];
    assign j_idx  = r_j[IW-1:0];
    assign cur_c  = r_phase ? r_val : r_old;
    assign up     = (r_req == REQ_APPEND) || r_phase;
    assign skip_i = (r_i != CW'(COLUMN_SLOTS)) &&
                    ((r_i >= r_loaded) || ((r_req == REQ_SWAP) && (i_idx == r_slot)));
    assign bump_addr = (r_i == CW'(COLUMN_SLOTS)) ? cur_c : (cur_c ^ r_cb);
    assign last_i = (r_i == CW'(COLUMN_SLOTS - 1));
    assign skip_j = (r_j != CW'(COLUMN_SLOTS)) && (j_idx == r_s);
    assign cnt_b  = m_rdata[5:0];
    assign cnt_a  = up ? ((cnt_b < 6'd63) ? cnt_b + 6'd1 : cnt_b)
                       : ((cnt_b > 6'd0) ? cnt_b - 6'd1 : 6'd0);
    assign full   = (r_loaded == CW'(COLUMN_SLOTS));
    assign rej    = m_rdata[6] || r_val == '0 ||
                    (r_req != REQ_APPEND && r_req != REQ_SWAP) ||
                    (r_req == REQ_APPEND && full) ||
                    (r_req == REQ_SWAP && !r_slot_ok);

    // addresses lead the index where it steps, so the registered data is current on use
    always_comb begin
        ca_addr = r_s;
        cb_addr = i_idx;
        unique case (r_st)
            S_CHK:  ca_addr = r_slot;
            S_CHKW: ca_addr = '0;
            S_WR:   cb_addr = (r_i == CW'(COLUMN_SLOTS)) ? '0 : i_idx + 1'b1;
            S_SRD, S_SRW: cb_addr = j_idx;
            S_SACC: begin
                cb_addr = (r_j == CW'(COLUMN_SLOTS)) ? '0 : j_idx + 1'b1;
                if (r_j == CW'(COLUMN_SLOTS - 1) && r_s != IW'(COLUMN_SLOTS - 1))
                    ca_addr = r_s + 1'b1;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_ca <= r_col[ca_addr];
        r_cb <= r_col[cb_addr];
    end

    always_comb begin
        m_raddr = bump_addr;
        m_waddr = bump_addr;
        m_wdata = {m_rdata[6], cnt_a};
        m_we    = 1'b0;
        unique case (r_st)
            S_CLR: begin
                m_we    = 1'b1;
                m_waddr = r_clr;
                m_wdata = (r_clr == '0) ? 7'd1 : 7'd0;
            end
            S_IDLE: m_raddr = SB'(i_new_column);
            S_CHK, S_CHKW: m_raddr = r_val;
            S_WR: m_we = !skip_i;
            S_MRD: m_raddr = r_phase ? r_val : r_old;
            S_MARK: begin
                m_we = 1'b1;
                m_waddr = r_phase ? r_val : r_old;
                m_wdata = {r_phase, m_rdata[5:0]};
                m_raddr = r_phase ? r_val : r_old;
            end
            S_SRD, S_SRW, S_SACC:
                m_raddr = (r_j == CW'(COLUMN_SLOTS)) ? r_ca : (r_ca ^ r_cb);
            default: ;
        endcase
    end

    // counts before/after drive totals
    logic [TW-1:0] hole_n, single_n;
    always_comb begin
        hole_n = r_hole;
        single_n = r_single;
        if (cnt_b == 6'd0 && cnt_a == 6'd1) begin
            hole_n = r_hole - 1'b1; single_n = r_single + 1'b1;
        end else if (cnt_b == 6'd1 && cnt_a == 6'd0) begin
            hole_n = r_hole + 1'b1; single_n = r_single - 1'b1;
        end else if (cnt_b == 6'd1 && cnt_a == 6'd2) begin
            single_n = r_single - 1'b1;
        end else if (cnt_b == 6'd2 && cnt_a == 6'd1) begin
            single_n = r_single + 1'b1;
        end
    end

    always_comb begin
        n_st = r_st;
        unique case (r_st)
            S_CLR:  if (r_clr == '1) n_st = (r_req == REQ_CLEAR) ? S_OUT : S_IDLE;
            S_IDLE: if (i_valid) n_st = (i_req_type == REQ_CLEAR) ? S_CLR : S_CHK;
            S_CHK:  n_st = S_CHKW;
            S_CHKW: n_st = rej ? S_SRD : S_RD;
            S_RD:   n_st = S_RW;
            S_RW:   n_st = S_WR;
            S_WR:   n_st = (r_i == CW'(COLUMN_SLOTS)) ? S_RD
                         : (last_i ? S_MRD : S_RD);
            S_MRD:  n_st = S_MARK;
            S_MARK: n_st = (r_req == REQ_SWAP && !r_phase) ? S_RD : S_SRD;
            S_SRD:  n_st = full ? S_SRW : S_OUT;
            S_SRW:  n_st = S_SACC;
            S_SACC: n_st = (r_j == CW'(COLUMN_SLOTS - 1) && r_s == IW'(COLUMN_SLOTS - 1))
                         ? S_OUT : S_SRD;
            S_OUT:  if (i_ready) n_st = S_IDLE;
            default: n_st = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= S_CLR; r_clr <= '0; r_loaded <= '0;
            r_hole <= HOLE_RST; r_single <= TW'(1);
            r_req <= REQ_APPEND;
        end else begin
            r_st <= n_st;
            unique case (r_st)
                S_CLR: begin
                    r_clr <= r_clr + 1'b1;
                    r_loaded <= '0; r_hole <= HOLE_RST; r_single <= TW'(1);
                    if (r_clr == '1 && r_req == REQ_CLEAR) r_status <= STAT_DONE;
                end
                S_IDLE: if (i_valid) begin
                    r_req  <= i_req_type;
                    r_slot <= i_slot[IW-1:0];
                    r_slot_ok <= (7'(i_slot) < 7'(r_loaded)) &&
                                 (7'(i_slot) < 7'(COLUMN_SLOTS));
                    r_val  <= SB'(i_new_column);
                    r_clr  <= '0;
                    r_phase <= 1'b0;
                    r_i <= CW'(COLUMN_SLOTS);
                end
                S_CHKW: begin
                    if (rej) begin
                        r_status <= STAT_REJ;
                    end else begin
                        r_status <= STAT_DONE;
                        r_phase <= (r_req == REQ_APPEND);
                        // the written slot is skipped by the pair update loop
                        if (r_req == REQ_APPEND) begin
                            r_col[r_loaded[IW-1:0]] <= r_val;
                        end else begin
                            r_col[r_slot] <= r_val;
                            r_old <= r_ca;
                        end
                    end
                    r_s <= '0; r_j <= CW'(COLUMN_SLOTS); r_dmg <= '0;
                    r_best <= '1; r_bslot <= '0;
                end
                S_WR: begin
                    if (!skip_i) begin r_hole <= hole_n; r_single <= single_n; end
                    r_i <= (r_i == CW'(COLUMN_SLOTS)) ? '0 : r_i + 1'b1;
                end
                S_MARK: begin
                    // mark written; then either the next swap phase or scoring
                    r_i <= CW'(COLUMN_SLOTS);
                    if (r_req == REQ_SWAP && !r_phase) r_phase <= 1'b1;
                    else if (r_req == REQ_APPEND) r_loaded <= r_loaded + 1'b1;
                end
                S_SACC: begin
                    if (!skip_j && m_rdata[5:0] == 6'd1) r_dmg <= r_dmg + 1'b1;
                    if (r_j == CW'(COLUMN_SLOTS - 1)) begin
                        if (((!skip_j && m_rdata[5:0] == 6'd1) ? r_dmg + 1'b1 : r_dmg)
                            < r_best) begin
                            r_best <= (!skip_j && m_rdata[5:0] == 6'd1) ?
                                      r_dmg + 1'b1 : r_dmg;
                            r_bslot <= r_s;
                        end
                        r_dmg <= '0;
                        r_j <= CW'(COLUMN_SLOTS);
                        if (r_s != IW'(COLUMN_SLOTS - 1)) r_s <= r_s + 1'b1;
                    end else begin
                        r_j <= (r_j == CW'(COLUMN_SLOTS)) ? '0 : r_j + 1'b1;
                    end
                end
                S_OUT: if (i_ready && r_req == REQ_CLEAR) r_req <= REQ_APPEND;
                default: ;
            endcase
        end
    end

    assign o_ready = (r_st == S_IDLE);
    assign o_valid = (r_st == S_OUT);
    assign o_status = r_status;
    assign o_uncovered_count = 11'(r_hole);
    assign o_single_count = 11'(r_single);
    assign o_score_valid = full;
    assign o_deletion_score = full ? 11'(r_hole + TW'(r_best)) : 11'd0;
    assign o_drop_slot = full ? 6'(r_bslot) : 6'd0;

    `SCC_ASSERT_IMP(a_excl, i_clk, i_rst_n, o_valid, !o_ready)
    `SCC_ASSERT_NEXT(a_hold, i_clk, i_rst_n, o_valid && !i_ready, o_valid && $stable(o_status))
    `SCC_ASSERT_IMP(a_loaded, i_clk, i_rst_n, 1'b1, r_loaded <= CW'(COLUMN_SLOTS))
endmodule
`default_nettype wire

// File: tb/sv/scc_checker.sv
// Checker for the syndrome coverage counter: watches both channels, predicts each result.
// Depends on scc_pkg.
`timescale 1ns / 1ps
`default_nettype none
module scc_checker import scc_pkg::*; #(
    parameter int SYN_BITS = SYN_BITS_DEF,
    parameter int SLOTS    = SLOTS_DEF
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_valid,
    input  wire         o_ready,
    input  wire [1:0]   i_req_type,
    input  wire [5:0]   i_slot,
    input  wire [9:0]   i_new_column,
    input  wire         o_valid,
    input  wire         i_ready,
    input  wire         o_status,
    input  wire [10:0]  o_uncovered_count,
    input  wire [10:0]  o_single_count,
    input  wire         o_score_valid,
    input  wire [10:0]  o_deletion_score,
    input  wire [5:0]   o_drop_slot,
    output int          errors,
    output int          pending
);
    localparam int NSYN = 1 << SYN_BITS;

    typedef struct packed {
        logic        status;
        logic [10:0] holes;
        logic [10:0] singles;
        logic        full;
        logic [10:0] score;
        logic [5:0]  drop_idx;
    } outcome_t;

    outcome_t          outcome_q[$];
    logic [SYN_BITS-1:0] columns[SLOTS];
    int unsigned       rep_count[NSYN];
    bit                present[NSYN];
    int unsigned       loaded;
    int unsigned       holes;
    int unsigned       singles;

    function automatic void clear_store();
        for (int s = 0; s < NSYN; s++) begin
            rep_count[s] = 0;
            present[s] = 0;
        end
        rep_count[0] = 1;
        loaded = 0;
        holes = NSYN - 1;
        singles = 1;
    endfunction

    function automatic void adjust(int unsigned syn, bit up);
        int unsigned was;
        int unsigned now;
        was = rep_count[syn];
        if (up) now = (was < 63) ? was + 1 : was;
        else now = (was > 0) ? was - 1 : 0;
        if (was == 0 && now == 1) begin
            holes--;
            singles++;
        end else if (was == 1 && now == 0) begin
            holes++;
            singles--;
        end else if (was == 1 && now == 2) begin
            singles--;
        end else if (was == 2 && now == 1) begin
            singles++;
        end
        rep_count[syn] = now;
    endfunction

    // the column itself plus its XOR with every other loaded column
    function automatic void add_column(logic [SYN_BITS-1:0] c, int skip, bit up);
        adjust(c, up);
        for (int i = 0; i < loaded; i++)
            if (i != skip) adjust(c ^ columns[i], up);
    endfunction

    function automatic outcome_t predict(logic [1:0] req, logic [5:0] slot,
                                         logic [9:0] raw);
        outcome_t            r;
        logic [SYN_BITS-1:0] val;
        logic [SYN_BITS-1:0] old;
        int unsigned         best;
        int unsigned         dmg;
        val = raw[SYN_BITS-1:0];
        r = '0;
        r.status = STAT_DONE;
        case (req)
            REQ_CLEAR: clear_store();
            REQ_APPEND: begin
                if (loaded >= SLOTS || val == 0 || present[val]) begin
                    r.status = STAT_REJ;
                end else begin
                    add_column(val, SLOTS, 1'b1);
                    present[val] = 1;
                    columns[loaded] = val;
                    loaded++;
                end
            end
            REQ_SWAP: begin
                if (slot >= loaded || val == 0 || present[val]) begin
                    r.status = STAT_REJ;
                end else begin
                    old = columns[slot];
                    add_column(old, slot, 1'b0);
                    add_column(val, slot, 1'b1);
                    present[old] = 0;
                    present[val] = 1;
                    columns[slot] = val;
                end
            end
            default: r.status = STAT_REJ;
        endcase
        r.holes = holes[10:0];
        r.singles = singles[10:0];
        r.full = (loaded == SLOTS);
        if (r.full) begin
            best = 32'hFFFF_FFFF;
            for (int s = 0; s < SLOTS; s++) begin
                dmg = (rep_count[columns[s]] == 1) ? 1 : 0;
                for (int i = 0; i < SLOTS; i++)
                    if (i != s && rep_count[columns[s] ^ columns[i]] == 1) dmg++;
                if (dmg < best) begin
                    best = dmg;
                    r.drop_idx = s[5:0];
                end
            end
            r.score = 11'(holes + best);
        end
        return r;
    endfunction

    always @(posedge i_clk) begin
        outcome_t want;
        int bad;
        bad = 0;
        if (!i_rst_n) begin
            clear_store();
            outcome_q.delete();
            errors <= 0;
        end else begin
            if (i_valid && o_ready)
                outcome_q.push_back(predict(i_req_type, i_slot, i_new_column));
            if (o_valid && i_ready) begin
                if (outcome_q.size() == 0) begin
                    $error("result with no request outstanding");
                    bad++;
                end else begin
                    want = outcome_q.pop_front();
                    if (o_status !== want.status) begin
                        $error("status exp %0d got %0d", want.status, o_status);
                        bad++;
                    end
                    if (o_uncovered_count !== want.holes) begin
                        $error("uncovered_count exp %0d got %0d", want.holes,
                               o_uncovered_count);
                        bad++;
                    end
                    if (o_single_count !== want.singles) begin
                        $error("single_count exp %0d got %0d", want.singles,
                               o_single_count);
                        bad++;
                    end
                    if (o_score_valid !== want.full) begin
                        $error("score_valid exp %0d got %0d", want.full, o_score_valid);
                        bad++;
                    end
                    if (o_deletion_score !== want.score) begin
                        $error("deletion_score exp %0d got %0d", want.score,
                               o_deletion_score);
                        bad++;
                    end
                    if (o_drop_slot !== want.drop_idx) begin
                        $error("drop_slot exp %0d got %0d", want.drop_idx,
                               o_drop_slot);
                        bad++;
                    end
                end
            end
            errors <= errors + bad;
        end
        pending <= outcome_q.size();
    end
endmodule
`default_nettype wire

// File: tb/sv/tb_top.sv
// Testbench top for the syndrome coverage counter: clock, reset, request stimulus, verdict.
// Depends on scc_pkg, syndrome_coverage_counter and scc_checker.
`timescale 1ns / 1ps
`default_nettype none
module tb_top;
    import scc_pkg::*;

    localparam int SLOTS = SLOTS_DEF;
    localparam longint CYCLE_LIMIT = 12_000_000;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_ready;
    logic [1:0]  i_req_type = REQ_CLEAR;
    logic [5:0]  i_slot = '0;
    logic [9:0]  i_new_column = '0;
    logic        o_valid;
    logic        i_ready = 1'b0;
    logic        o_status;
    logic [10:0] o_uncovered_count;
    logic [10:0] o_single_count;
    logic        o_score_valid;
    logic [10:0] o_deletion_score;
    logic [5:0]  o_drop_slot;
    int          errors;
    int          pending;

    bit          no_gaps;
    bit          used[1024];
    int          top_loaded;
    longint      cycles;
    int          rx_gap;
    int          rx_hold;
    int          taken;

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    syndrome_coverage_counter u_top (.*);

    scc_checker u_checker (.*);

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // result side: random stalls, one long hold-off after 40 results
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_ready <= 1'b0;
        end else begin
            if (o_valid && i_ready) begin
                taken++;
                rx_gap = no_gaps ? 0 : $urandom_range(0, 9);
                if (taken == 40) rx_hold = 400;
            end else if (rx_hold > 0) begin
                rx_hold--;
            end else if (rx_gap > 0) begin
                rx_gap--;
            end
            i_ready <= (rx_hold == 0 && rx_gap == 0);
        end
    end

    task automatic send(logic [1:0] req, logic [5:0] slot, logic [9:0] col);
        int gap;
        gap = no_gaps ? 0 : $urandom_range(0, 9);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_req_type <= req;
        i_slot <= slot;
        i_new_column <= col;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        if (req == REQ_CLEAR) begin
            top_loaded = 0;
            used = '{default: 0};
        end else if (req == REQ_APPEND && top_loaded < SLOTS && col != 0 && !used[col]) begin
            top_loaded++;
        end
        if (col != 0) used[col] = 1;
    endtask

    function automatic logic [9:0] fresh_column();
        logic [9:0] v;
        do v = 10'($urandom_range(1, 1023)); while (used[v]);
        return v;
    endfunction

    task automatic drain();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
    endtask

    initial begin
        int n_swaps;
        int fill;
        int pick;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: empty-store corners and every rejection except append when full
        send(REQ_APPEND, 6'd0, 10'd0);
        send(REQ_APPEND, 6'd63, 10'd1023);
        send(REQ_APPEND, 6'd0, 10'h200);
        send(REQ_APPEND, 6'd0, 10'h155);
        send(REQ_APPEND, 6'd0, 10'h2AA);
        send(REQ_APPEND, 6'd0, 10'h155);
        send(REQ_SWAP, 6'd63, 10'h001);
        send(REQ_SWAP, 6'd3, 10'h001);
        send(REQ_SWAP, 6'd0, 10'h3FF);
        send(REQ_SWAP, 6'd1, 10'd0);
        send(REQ_SWAP, 6'd1, 10'h001);
        send(2'd3, 6'd21, 10'h0F0);
        send(REQ_SWAP, 6'd1, 10'h200);
        send(REQ_CLEAR, 6'd42, 10'h3FF);
        // directed: fill to full, then append when full
        while (top_loaded < SLOTS) send(REQ_APPEND, 6'd0, fresh_column());
        send(REQ_APPEND, 6'd0, fresh_column());
        send(REQ_SWAP, 6'd0, fresh_column());
        send(REQ_SWAP, 6'(SLOTS - 1), fresh_column());
        send(REQ_SWAP, 6'(SLOTS), fresh_column());
        // sender pause until everything is back
        drain();

        for (int phase = 0; phase < 3; phase++) begin
            no_gaps = (phase == 2);
            send(REQ_CLEAR, 6'($urandom), 10'($urandom));
            fill = ($urandom_range(0, 3) == 0) ? $urandom_range(2, 20) : SLOTS;
            while (top_loaded < fill) send(REQ_APPEND, 6'($urandom), fresh_column());
            n_swaps = (fill == SLOTS) ? 14 : 6;
            for (int k = 0; k < n_swaps; k++) begin
                pick = $urandom_range(0, 9);
                case (pick)
                    0: send(REQ_SWAP, 6'($urandom_range(top_loaded, 63)), fresh_column());
                    1: send(REQ_SWAP, 6'($urandom_range(0, top_loaded - 1)),
                            10'($urandom_range(0, 1)));
                    2: send(2'($urandom_range(1, 3)), 6'($urandom), 10'($urandom));
                    default: send(REQ_SWAP, 6'($urandom_range(0, top_loaded - 1)),
                                  fresh_column());
                endcase
            end
        end
        drain();
        repeat (50) @(posedge i_clk);
        if (errors == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end
endmodule
`default_nettype wire

// File: syndrome_coverage_counter.f
+incdir+hdl
hdl/scc_pkg.sv
hdl/scc_count_mem.sv
hdl/syndrome_coverage_counter.sv
tb/sv/scc_checker.sv
tb/sv/tb_top.sv
